// ===== hdl/rhcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV color classifier package
// Shared types, register layout, class codes and fixed constants.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int CLASS_W    = 3;
    localparam int HUE_OUT_W  = 16;
    localparam int SAT_OUT_W  = 13;
    localparam int VALUE_W    = 7;
    localparam int VALUE_MAX  = 100;

    localparam int DEG_SECTOR    = 60;
    localparam int HUE_GREEN_OFS = 120;
    localparam int HUE_BLUE_OFS  = 240;
    localparam int PERCENT       = 100;
    localparam int RED_WRAP      = 340;
    localparam int YELLOW_HUE    = 50;
    localparam int WIN_10        = 10;
    localparam int WIN_15        = 15;
    localparam int WIN_20        = 20;
    localparam int WIN_30        = 30;
    localparam int WIN_40        = 40;
    localparam int WIN_70        = 70;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLACK_HUE = 3'd0,
        CFG_BLACK_SAT = 3'd1,
        CFG_BLACK_VAL = 3'd2,
        CFG_GREEN_HUE = 3'd3,
        CFG_RED_HUE   = 3'd4,
        CFG_BLUE_HUE  = 3'd5,
        CFG_BLUE_SAT  = 3'd6,
        CFG_BLUE_VAL  = 3'd7
    } rhcc_cfg_idx_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_INVALID = 3'd0,
        CLASS_BLACK   = 3'd1,
        CLASS_GREEN   = 3'd2,
        CLASS_RED     = 3'd3,
        CLASS_BLUE    = 3'd4,
        CLASS_YELLOW  = 3'd5
    } rhcc_class_t;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } rhcc_chan_t;

    typedef struct packed {
        logic [8:0] black_hue;
        logic [6:0] black_sat;
        logic [6:0] black_val;
        logic [8:0] green_hue;
        logic [8:0] red_hue;
        logic [8:0] blue_hue;
        logic [6:0] blue_sat;
        logic [6:0] blue_val;
    } rhcc_cfg_t;

    localparam rhcc_cfg_t CFG_RESET = '{
        black_hue: 9'd240,
        black_sat: 7'd30,
        black_val: 7'd60,
        green_hue: 9'd120,
        red_hue:   9'd0,
        blue_hue:  9'd220,
        blue_sat:  7'd90,
        blue_val:  7'd100
    };

    typedef struct packed {
        logic               hue_undef;
        logic               hue_neg;
        logic               sat_zero;
        logic [VALUE_W-1:0] value;
    } rhcc_side_t;

    typedef struct packed {
        logic [CLASS_W-1:0]   color_class;
        logic [HUE_OUT_W-1:0] hue_fx;
        logic [SAT_OUT_W-1:0] sat_fx;
        logic [VALUE_W-1:0]   value_level;
    } rhcc_result_t;

endpackage
`default_nettype wire

// ===== hdl/rgb_hsv_color_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each accepted request passes the front end, divider, classifier and output buffer.
// Throughput: one request per cycle while pix_stall is low; the restoring divider
// pipeline, one quotient bit per stage, sets the depth.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset clears all valid bits and loads the reference registers with defaults.
// ----------------------------------------------------------------------------
// RGB to HSV color classifier
// Converts a raw RGB request to fixed-point hue, saturation and value and
// classifies it against the reference color windows.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier
    import rhcc_pkg::*;
#(
    parameter int RAW_BITS  = 10,
    parameter int FRAC_BITS = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    output      logic                  pix_stall,
    input  wire logic [RAW_BITS-1:0]   red_raw,
    input  wire logic [RAW_BITS-1:0]   green_raw,
    input  wire logic [RAW_BITS-1:0]   blue_raw,
    output      logic                  res_valid,
    input  wire logic                  res_stall,
    output      logic [CLASS_W-1:0]    color_class,
    output      logic signed [HUE_OUT_W-1:0] hue_fx,
    output      logic [SAT_OUT_W-1:0]  sat_fx,
    output      logic [VALUE_W-1:0]    value_level,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int Q_W   = FRAC_BITS + 9;
    localparam int NUM_W = RAW_BITS + Q_W;

    rhcc_cfg_t           cfg_reg, cfg_next;

    logic                en;
    logic                prep_valid;
    logic [NUM_W-1:0]    prep_hue_num, prep_sat_num;
    logic [RAW_BITS-1:0] prep_hue_den, prep_sat_den;
    rhcc_side_t          prep_side;

    logic                div_valid;
    logic [Q_W-1:0]      div_hue_quo, div_sat_quo;
    rhcc_side_t          div_side;

    logic                cls_valid;
    rhcc_result_t        cls_result;

    logic                head_valid_reg, head_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    rhcc_result_t        head_reg, head_next;
    rhcc_result_t        skid_reg, skid_next;
    logic                push, pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (rhcc_cfg_idx_t'(cfg_index))
                CFG_BLACK_HUE: cfg_next.black_hue = cfg_data;
                CFG_BLACK_SAT: cfg_next.black_sat = cfg_data[6:0];
                CFG_BLACK_VAL: cfg_next.black_val = cfg_data[6:0];
                CFG_GREEN_HUE: cfg_next.green_hue = cfg_data;
                CFG_RED_HUE:   cfg_next.red_hue   = cfg_data;
                CFG_BLUE_HUE:  cfg_next.blue_hue  = cfg_data;
                CFG_BLUE_SAT:  cfg_next.blue_sat  = cfg_data[6:0];
                CFG_BLUE_VAL:  cfg_next.blue_val  = cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline halts only when both output entries are full and stalled.
    assign en        = !(skid_valid_reg && res_stall);
    assign pix_stall = !en;

    rhcc_prep #(
        .RAW_BITS  (RAW_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .red_raw   (red_raw),
        .green_raw (green_raw),
        .blue_raw  (blue_raw),
        .out_valid (prep_valid),
        .hue_num   (prep_hue_num),
        .hue_den   (prep_hue_den),
        .sat_num   (prep_sat_num),
        .sat_den   (prep_sat_den),
        .side      (prep_side)
    );

    rhcc_div #(
        .RAW_BITS  (RAW_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .hue_num   (prep_hue_num),
        .hue_den   (prep_hue_den),
        .sat_num   (prep_sat_num),
        .sat_den   (prep_sat_den),
        .side_in   (prep_side),
        .out_valid (div_valid),
        .hue_quo   (div_hue_quo),
        .sat_quo   (div_sat_quo),
        .side_out  (div_side)
    );

    rhcc_classify #(
        .FRAC_BITS (FRAC_BITS)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .hue_quo   (div_hue_quo),
        .sat_quo   (div_sat_quo),
        .side      (div_side),
        .cfg       (cfg_reg),
        .out_valid (cls_valid),
        .result    (cls_result)
    );

    assign push = cls_valid && en;
    assign pop  = head_valid_reg && !res_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = cls_result;
            end
            else
            begin
                head_valid_next = push;
                head_next       = cls_result;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_next       = cls_result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = cls_result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign res_valid   = head_valid_reg;
    assign color_class = head_reg.color_class;
    assign hue_fx      = head_reg.hue_fx;
    assign sat_fx      = head_reg.sat_fx;
    assign value_level = head_reg.value_level;

endmodule
`default_nettype wire

// ===== hdl/rhcc_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two stages: channel maximum, minimum and range, then the hue and
// saturation dividends, divisors and special-case flags.
// ----------------------------------------------------------------------------
module rhcc_prep
    import rhcc_pkg::*;
#(
    parameter int RAW_BITS  = 10,
    parameter int FRAC_BITS = 6,
    localparam int Q_W      = FRAC_BITS + 9,
    localparam int NUM_W    = RAW_BITS + Q_W
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [RAW_BITS-1:0] red_raw,
    input  wire logic [RAW_BITS-1:0] green_raw,
    input  wire logic [RAW_BITS-1:0] blue_raw,
    output      logic                out_valid,
    output      logic [NUM_W-1:0]    hue_num,
    output      logic [RAW_BITS-1:0] hue_den,
    output      logic [NUM_W-1:0]    sat_num,
    output      logic [RAW_BITS-1:0] sat_den,
    output      rhcc_side_t          side
);

    localparam int TW = RAW_BITS + 10;

    logic                       valid_s1_reg;
    logic [RAW_BITS-1:0]        max_s1_reg, max_s1_next;
    logic [RAW_BITS-1:0]        range_s1_reg, range_s1_next;
    logic signed [RAW_BITS:0]   diff_s1_reg, diff_s1_next;
    rhcc_chan_t                 chan_s1_reg, chan_s1_next;
    logic [VALUE_W-1:0]         value_s1_reg, value_s1_next;

    logic                       valid_s2_reg;
    logic [NUM_W-1:0]           hue_num_reg, hue_num_next;
    logic [RAW_BITS-1:0]        hue_den_reg;
    logic [NUM_W-1:0]           sat_num_reg, sat_num_next;
    logic [RAW_BITS-1:0]        sat_den_reg;
    rhcc_side_t                 side_reg, side_next;

    logic [RAW_BITS-1:0]        min_s1;
    logic signed [TW-1:0]       hue_term;
    logic [TW-1:0]              hue_mag;
    logic [RAW_BITS:0]          quirk_sum;
    logic [RAW_BITS+6:0]        sat_pct;
    int                         hue_ofs;

    always_comb
    begin
        if (red_raw >= green_raw && red_raw >= blue_raw)
        begin
            chan_s1_next = CHAN_RED;
        end
        else if (green_raw >= blue_raw)
        begin
            chan_s1_next = CHAN_GREEN;
        end
        else
        begin
            chan_s1_next = CHAN_BLUE;
        end

        if (red_raw <= green_raw)
        begin
            min_s1 = (red_raw <= blue_raw) ? red_raw : blue_raw;
        end
        else
        begin
            min_s1 = (green_raw <= blue_raw) ? green_raw : blue_raw;
        end

        unique case (chan_s1_next)
            CHAN_RED:
            begin
                max_s1_next  = red_raw;
                diff_s1_next = $signed({1'b0, green_raw}) - $signed({1'b0, blue_raw});
            end
            CHAN_GREEN:
            begin
                max_s1_next  = green_raw;
                diff_s1_next = $signed({1'b0, blue_raw}) - $signed({1'b0, red_raw});
            end
            default:
            begin
                max_s1_next  = blue_raw;
                diff_s1_next = $signed({1'b0, red_raw}) - $signed({1'b0, green_raw});
            end
        endcase

        range_s1_next = max_s1_next - min_s1;
        value_s1_next = (max_s1_next > RAW_BITS'(VALUE_MAX)) ?
                        VALUE_W'(VALUE_MAX) : max_s1_next[VALUE_W-1:0];
    end

    always_comb
    begin
        unique case (chan_s1_reg)
            CHAN_RED:   hue_ofs = 0;
            CHAN_GREEN: hue_ofs = HUE_GREEN_OFS;
            default:    hue_ofs = HUE_BLUE_OFS;
        endcase

        hue_term = TW'(diff_s1_reg) * $signed(TW'(DEG_SECTOR))
                 + $signed({{(TW-RAW_BITS){1'b0}}, range_s1_reg}) * $signed(TW'(hue_ofs));
        hue_mag  = hue_term[TW-1] ? TW'(-hue_term) : TW'(hue_term);
        hue_num_next = {hue_mag[RAW_BITS+8:0], {FRAC_BITS{1'b0}}};

        sat_pct      = (RAW_BITS+7)'(range_s1_reg) * (RAW_BITS+7)'(PERCENT);
        sat_num_next = {2'b00, sat_pct, {FRAC_BITS{1'b0}}};

        // A red hue whose ratio is exactly minus one reports as undefined.
        quirk_sum = diff_s1_reg + {1'b0, range_s1_reg};

        side_next.hue_undef = (range_s1_reg == '0) ||
                              (chan_s1_reg == CHAN_RED && quirk_sum == '0);
        side_next.hue_neg   = hue_term[TW-1];
        side_next.sat_zero  = (max_s1_reg == '0);
        side_next.value     = value_s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_s1_reg <= in_valid;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_s1_reg   <= max_s1_next;
            range_s1_reg <= range_s1_next;
            diff_s1_reg  <= diff_s1_next;
            chan_s1_reg  <= chan_s1_next;
            value_s1_reg <= value_s1_next;
            hue_num_reg  <= hue_num_next;
            hue_den_reg  <= range_s1_reg;
            sat_num_reg  <= sat_num_next;
            sat_den_reg  <= max_s1_reg;
            side_reg     <= side_next;
        end
    end

    assign out_valid = valid_s2_reg;
    assign hue_num   = hue_num_reg;
    assign hue_den   = hue_den_reg;
    assign sat_num   = sat_num_reg;
    assign sat_den   = sat_den_reg;
    assign side      = side_reg;

endmodule
`default_nettype wire

// ===== hdl/rhcc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-lane pipelined divider
// Restoring division, one quotient bit per stage, for the hue and the
// saturation lanes in lockstep, with the item flags carried alongside.
// ----------------------------------------------------------------------------
module rhcc_div
    import rhcc_pkg::*;
#(
    parameter int RAW_BITS  = 10,
    parameter int FRAC_BITS = 6,
    localparam int Q_W      = FRAC_BITS + 9,
    localparam int NUM_W    = RAW_BITS + Q_W
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [NUM_W-1:0]    hue_num,
    input  wire logic [RAW_BITS-1:0] hue_den,
    input  wire logic [NUM_W-1:0]    sat_num,
    input  wire logic [RAW_BITS-1:0] sat_den,
    input  wire rhcc_side_t          side_in,
    output      logic                out_valid,
    output      logic [Q_W-1:0]      hue_quo,
    output      logic [Q_W-1:0]      sat_quo,
    output      rhcc_side_t          side_out
);

    logic                valid_reg [Q_W];
    logic                valid_next [Q_W];
    logic [RAW_BITS-1:0] hrem_reg [Q_W];
    logic [RAW_BITS-1:0] hrem_next [Q_W];
    logic [Q_W-1:0]      hnq_reg [Q_W];
    logic [Q_W-1:0]      hnq_next [Q_W];
    logic [RAW_BITS-1:0] hden_reg [Q_W];
    logic [RAW_BITS-1:0] hden_next [Q_W];
    logic [RAW_BITS-1:0] srem_reg [Q_W];
    logic [RAW_BITS-1:0] srem_next [Q_W];
    logic [Q_W-1:0]      snq_reg [Q_W];
    logic [Q_W-1:0]      snq_next [Q_W];
    logic [RAW_BITS-1:0] sden_reg [Q_W];
    logic [RAW_BITS-1:0] sden_next [Q_W];
    rhcc_side_t          side_reg [Q_W];
    rhcc_side_t          side_next [Q_W];

    function automatic logic [RAW_BITS:0] div_step(
        input logic [RAW_BITS-1:0] rem,
        input logic                nbit,
        input logic [RAW_BITS-1:0] den
    );
        logic [RAW_BITS:0] trial;
        logic [RAW_BITS:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
        begin
            return {1'b1, diff[RAW_BITS-1:0]};
        end
        return {1'b0, trial[RAW_BITS-1:0]};
    endfunction

    always_comb
    begin
        logic [RAW_BITS-1:0] hrem_in, srem_in, hden_in, sden_in;
        logic [Q_W-1:0]      hnq_in, snq_in;
        logic [RAW_BITS:0]   hstep, sstep;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                side_next[k]  = side_in;
                hrem_in       = hue_num[NUM_W-1:Q_W];
                hnq_in        = hue_num[Q_W-1:0];
                hden_in       = hue_den;
                srem_in       = sat_num[NUM_W-1:Q_W];
                snq_in        = sat_num[Q_W-1:0];
                sden_in       = sat_den;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                side_next[k]  = side_reg[k-1];
                hrem_in       = hrem_reg[k-1];
                hnq_in        = hnq_reg[k-1];
                hden_in       = hden_reg[k-1];
                srem_in       = srem_reg[k-1];
                snq_in        = snq_reg[k-1];
                sden_in       = sden_reg[k-1];
            end
            hstep        = div_step(hrem_in, hnq_in[Q_W-1], hden_in);
            sstep        = div_step(srem_in, snq_in[Q_W-1], sden_in);
            hrem_next[k] = hstep[RAW_BITS-1:0];
            hnq_next[k]  = {hnq_in[Q_W-2:0], hstep[RAW_BITS]};
            hden_next[k] = hden_in;
            srem_next[k] = sstep[RAW_BITS-1:0];
            snq_next[k]  = {snq_in[Q_W-2:0], sstep[RAW_BITS]};
            sden_next[k] = sden_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                hrem_reg[k] <= hrem_next[k];
                hnq_reg[k]  <= hnq_next[k];
                hden_reg[k] <= hden_next[k];
                srem_reg[k] <= srem_next[k];
                snq_reg[k]  <= snq_next[k];
                sden_reg[k] <= sden_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign hue_quo   = hnq_reg[Q_W-1];
    assign sat_quo   = snq_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule
`default_nettype wire

// ===== hdl/rhcc_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hue and saturation finishing and color window classification
// One register stage forms the signed hue and the saturation; the window
// tests and the priority encoding follow it.
// ----------------------------------------------------------------------------
module rhcc_classify
    import rhcc_pkg::*;
#(
    parameter int FRAC_BITS = 6,
    localparam int Q_W      = FRAC_BITS + 9
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [Q_W-1:0] hue_quo,
    input  wire logic [Q_W-1:0] sat_quo,
    input  wire rhcc_side_t     side,
    input  wire rhcc_cfg_t      cfg,
    output      logic           out_valid,
    output      rhcc_result_t   result
);

    localparam int CW = FRAC_BITS + 12;
    localparam int HW = (CW > HUE_OUT_W) ? CW : HUE_OUT_W;
    localparam int SW = (Q_W > SAT_OUT_W) ? Q_W : SAT_OUT_W;
    localparam int VW = VALUE_W + 2;
    localparam logic signed [CW-1:0] HUE_UNDEF = -(CW'(1) << FRAC_BITS);

    logic                  valid_a_reg;
    logic signed [CW-1:0]  hue_a_reg, hue_a_next;
    logic [Q_W-1:0]        sat_a_reg, sat_a_next;
    logic [VALUE_W-1:0]    value_a_reg;

    logic signed [CW-1:0]  sat_s;
    logic signed [VW-1:0]  val_s;
    logic signed [HW-1:0]  hue_wide;
    logic [SW-1:0]         sat_wide;
    logic                  is_black, is_green, is_red, is_blue, is_yellow;
    rhcc_class_t           cls;

    function automatic logic signed [CW-1:0] deg_thr(input logic [8:0] base, input int ofs);
        logic signed [CW-1:0] sum;
        sum = $signed(CW'(base)) + $signed(CW'(ofs));
        return sum <<< FRAC_BITS;
    endfunction

    function automatic logic signed [VW-1:0] val_thr(input logic [6:0] base, input int ofs);
        return $signed(VW'(base)) + $signed(VW'(ofs));
    endfunction

    always_comb
    begin
        if (side.hue_undef)
        begin
            hue_a_next = HUE_UNDEF;
        end
        else if (side.hue_neg)
        begin
            hue_a_next = -$signed(CW'(hue_quo));
        end
        else
        begin
            hue_a_next = $signed(CW'(hue_quo));
        end
        sat_a_next = side.sat_zero ? '0 : sat_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_a_reg   <= hue_a_next;
            sat_a_reg   <= sat_a_next;
            value_a_reg <= side.value;
        end
    end

    always_comb
    begin
        sat_s = $signed(CW'(sat_a_reg));
        val_s = $signed(VW'(value_a_reg));

        is_black = deg_thr(cfg.black_hue, -WIN_10) <= hue_a_reg
                && hue_a_reg <= deg_thr(cfg.black_hue, WIN_10)
                && deg_thr({2'b00, cfg.black_sat}, -WIN_10) <= sat_s
                && sat_s <= deg_thr({2'b00, cfg.black_sat}, WIN_10)
                && val_thr(cfg.black_val, -WIN_10) <= val_s
                && val_s <= val_thr(cfg.black_val, WIN_10);

        is_green = deg_thr(cfg.green_hue, -WIN_30) < hue_a_reg
                && hue_a_reg < deg_thr(cfg.green_hue, WIN_70)
                && val_s > val_thr(cfg.black_val, WIN_10);

        is_red = hue_a_reg < deg_thr(cfg.red_hue, WIN_20)
              || deg_thr('0, RED_WRAP) < hue_a_reg;

        is_blue = deg_thr(cfg.blue_hue, -WIN_10) <= hue_a_reg
               && hue_a_reg <= deg_thr(cfg.blue_hue, WIN_40)
               && deg_thr({2'b00, cfg.blue_sat}, -WIN_20) <= sat_s
               && sat_s <= deg_thr({2'b00, cfg.blue_sat}, WIN_20)
               && val_thr(cfg.blue_val, -WIN_15) <= val_s
               && val_s <= val_thr(cfg.blue_val, 0);

        is_yellow = deg_thr('0, YELLOW_HUE - WIN_30) < hue_a_reg
                 && hue_a_reg < deg_thr('0, YELLOW_HUE + WIN_30);

        priority if (is_black)
        begin
            cls = CLASS_BLACK;
        end
        else if (is_green)
        begin
            cls = CLASS_GREEN;
        end
        else if (is_red)
        begin
            cls = CLASS_RED;
        end
        else if (is_blue)
        begin
            cls = CLASS_BLUE;
        end
        else if (is_yellow)
        begin
            cls = CLASS_YELLOW;
        end
        else
        begin
            cls = CLASS_INVALID;
        end
    end

    assign hue_wide = HW'(hue_a_reg);
    assign sat_wide = SW'(sat_a_reg);

    assign out_valid          = valid_a_reg;
    assign result.color_class = cls;
    assign result.hue_fx      = hue_wide[HUE_OUT_W-1:0];
    assign result.sat_fx      = sat_wide[SAT_OUT_W-1:0];
    assign result.value_level = value_a_reg;

endmodule
`default_nettype wire

// ===== hdl/rhcc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV color classifier port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rhcc_checker
    import rhcc_pkg::*;
#(
    parameter int RAW_BITS = 10
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        pix_valid,
    input wire logic                        pix_stall,
    input wire logic [RAW_BITS-1:0]         red_raw,
    input wire logic [RAW_BITS-1:0]         green_raw,
    input wire logic [RAW_BITS-1:0]         blue_raw,
    input wire logic                        res_valid,
    input wire logic                        res_stall,
    input wire logic [CLASS_W-1:0]          color_class,
    input wire logic signed [HUE_OUT_W-1:0] hue_fx,
    input wire logic [SAT_OUT_W-1:0]        sat_fx,
    input wire logic [VALUE_W-1:0]          value_level
);

    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !res_valid |-> !pix_stall
    ) else $error("request stalled while no result is pending");

    a_stall_from_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_stall
    ) else $error("request stalled without a stalled result");

    a_request_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(red_raw) && $stable(green_raw)
                                   && $stable(blue_raw)
    ) else $error("stalled request changed");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(color_class) && $stable(hue_fx)
                                   && $stable(sat_fx) && $stable(value_level)
    ) else $error("stalled result changed");

    a_result_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> value_level <= VALUE_W'(VALUE_MAX) && color_class <= CLASS_YELLOW
    ) else $error("result value or class out of range");

endmodule

bind rgb_hsv_color_classifier rhcc_checker #(
    .RAW_BITS (RAW_BITS)
) u_rhcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .red_raw     (red_raw),
    .green_raw   (green_raw),
    .blue_raw    (blue_raw),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .color_class (color_class),
    .hue_fx      (hue_fx),
    .sat_fx      (sat_fx),
    .value_level (value_level)
);
`default_nettype wire

// ===== tb/rgb_hsv_color_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV color classifier testbench
// Drives raw RGB requests through the classifier under several reference
// window settings, with random idle and stall bursts on both sides. For each
// accepted request it expects a tabled or predicted hue, saturation, value
// and class, and checks each result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier_tb;
    import rhcc_pkg::*;

    localparam int     RAW      = 10;
    localparam int     FRAC     = 6;
    localparam int     PIPE_LAT = FRAC + 13;
    localparam longint DEG      = 64'sd1 << FRAC;

    typedef struct packed {
        logic [RAW-1:0] r;
        logic [RAW-1:0] g;
        logic [RAW-1:0] b;
        logic           known;
        rhcc_result_t   want;
    } pix_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    logic [RAW-1:0]        red_raw = '0;
    logic [RAW-1:0]        green_raw = '0;
    logic [RAW-1:0]        blue_raw = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [CLASS_W-1:0]    color_class;
    logic signed [HUE_OUT_W-1:0] hue_fx;
    logic [SAT_OUT_W-1:0]  sat_fx;
    logic [VALUE_W-1:0]    value_level;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rhcc_cfg_t    window_cfg = CFG_RESET;
    rhcc_result_t pending_hsv[$];
    rhcc_result_t oldest_hsv;
    pix_row_t     sample_rows[$];
    int           bad_results = 0;
    int           stall_left = 0;
    bit           calm = 1'b0;
    bit           src_idles = 1'b1;
    bit           sink_idles = 1'b1;

    rgb_hsv_color_classifier #(.RAW_BITS(RAW), .FRAC_BITS(FRAC)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .red_raw     (red_raw),
        .green_raw   (green_raw),
        .blue_raw    (blue_raw),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .color_class (color_class),
        .hue_fx      (hue_fx),
        .sat_fx      (sat_fx),
        .value_level (value_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic rhcc_result_t classify_rgb(logic [RAW-1:0] r_in, logic [RAW-1:0] g_in,
                                                  logic [RAW-1:0] b_in);
        longint       r, g, b, mx, mn, c, hue, sat, v, bh, bs, bv;
        rhcc_class_t  cls;
        rhcc_result_t res;
        r = longint'(r_in);
        g = longint'(g_in);
        b = longint'(b_in);
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (mn < b) ? mn : b;
        c = mx - mn;
        if (c == 0)
            hue = -DEG;
        else if (mx == r)
            hue = (g - b == -c) ? -DEG : (60 * DEG * (g - b)) / c;
        else if (mx == g)
            hue = (60 * DEG * (b - r) + 120 * DEG * c) / c;
        else
            hue = (60 * DEG * (r - g) + 240 * DEG * c) / c;
        sat = (mx == 0) ? 0 : (100 * DEG * c) / mx;
        v = (mx > 100) ? 100 : mx;
        bh = longint'(window_cfg.black_hue);
        bs = longint'(window_cfg.black_sat);
        bv = longint'(window_cfg.black_val);
        if ((bh - 10) * DEG <= hue && hue <= (bh + 10) * DEG &&
            (bs - 10) * DEG <= sat && sat <= (bs + 10) * DEG &&
            bv - 10 <= v && v <= bv + 10)
            cls = CLASS_BLACK;
        else if ((longint'(window_cfg.green_hue) - 30) * DEG < hue &&
                 hue < (longint'(window_cfg.green_hue) + 70) * DEG && v > bv + 10)
            cls = CLASS_GREEN;
        else if (hue < (longint'(window_cfg.red_hue) + 20) * DEG || 340 * DEG < hue)
            cls = CLASS_RED;
        else if ((longint'(window_cfg.blue_hue) - 10) * DEG <= hue &&
                 hue <= (longint'(window_cfg.blue_hue) + 40) * DEG &&
                 (longint'(window_cfg.blue_sat) - 20) * DEG <= sat &&
                 sat <= (longint'(window_cfg.blue_sat) + 20) * DEG &&
                 longint'(window_cfg.blue_val) - 15 <= v &&
                 v <= longint'(window_cfg.blue_val))
            cls = CLASS_BLUE;
        else if (20 * DEG < hue && hue < 80 * DEG)
            cls = CLASS_YELLOW;
        else
            cls = CLASS_INVALID;
        res.color_class = cls;
        res.hue_fx = hue[HUE_OUT_W-1:0];
        res.sat_fx = sat[SAT_OUT_W-1:0];
        res.value_level = v[VALUE_W-1:0];
        return res;
    endfunction

    task automatic add_row(input int r, input int g, input int b, input bit known,
                           input rhcc_class_t cls, input int hue, input int sat, input int val);
        pix_row_t row;
        row.r = RAW'(r);
        row.g = RAW'(g);
        row.b = RAW'(b);
        row.known = known;
        row.want.color_class = cls;
        row.want.hue_fx = HUE_OUT_W'(hue);
        row.want.sat_fx = SAT_OUT_W'(sat);
        row.want.value_level = VALUE_W'(val);
        sample_rows.push_back(row);
    endtask

    task automatic send_pixel(input logic [RAW-1:0] r, input logic [RAW-1:0] g,
                              input logic [RAW-1:0] b, input bit known, input rhcc_result_t want);
        int gap;
        @(negedge clk);
        if (!calm && src_idles && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        red_raw <= r;
        green_raw <= g;
        blue_raw <= b;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        if (known)
            pending_hsv.push_back(want);
        else
            pending_hsv.push_back(classify_rgb(r, g, b));
    endtask

    task automatic send_random(input int count);
        logic [RAW-1:0] ch[3];
        int             top, span, hi, lo, v;
        rhcc_result_t   none;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    for (int k = 0; k < 3; k++)
                        ch[k] = RAW'($urandom_range(0, 1023));
                end
                1:
                begin
                    for (int k = 0; k < 3; k++)
                        ch[k] = RAW'($urandom_range(0, 127));
                end
                2:
                begin
                    top = $urandom_range(20, 115);
                    span = $urandom_range(0, top);
                    for (int k = 0; k < 3; k++)
                        ch[k] = RAW'($urandom_range(top - span, top));
                    hi = $urandom_range(0, 2);
                    lo = (hi + 1 + $urandom_range(0, 1)) % 3;
                    ch[hi] = RAW'(top);
                    ch[lo] = RAW'(top - span);
                end
                default:
                begin
                    v = $urandom_range(0, 1023);
                    for (int k = 0; k < 3; k++)
                        ch[k] = RAW'(v);
                    if ($urandom_range(0, 1))
                        ch[$urandom_range(0, 2)] = $urandom_range(0, 1) ? '0 : '1;
                end
            endcase
            send_pixel(ch[0], ch[1], ch[2], 1'b0, none);
        end
    endtask

    task automatic settle;
        @(negedge clk);
        pix_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // Settings: 0 reset defaults, 1 all zero, 2 all ones, 3 random in range.
    task automatic load_windows(input int setting);
        rhcc_cfg_idx_t  idx;
        logic [8:0]     data;
        bit             is_hue;
        for (int i = 0; i < 8; i++)
        begin
            idx = rhcc_cfg_idx_t'(i);
            is_hue = (idx == CFG_BLACK_HUE || idx == CFG_GREEN_HUE ||
                      idx == CFG_RED_HUE || idx == CFG_BLUE_HUE);
            case (setting)
                0:
                    case (idx)
                        CFG_BLACK_HUE: data = CFG_RESET.black_hue;
                        CFG_BLACK_SAT: data = 9'(CFG_RESET.black_sat);
                        CFG_BLACK_VAL: data = 9'(CFG_RESET.black_val);
                        CFG_GREEN_HUE: data = CFG_RESET.green_hue;
                        CFG_RED_HUE:   data = CFG_RESET.red_hue;
                        CFG_BLUE_HUE:  data = CFG_RESET.blue_hue;
                        CFG_BLUE_SAT:  data = 9'(CFG_RESET.blue_sat);
                        default:       data = 9'(CFG_RESET.blue_val);
                    endcase
                1:
                    data = '0;
                2:
                    data = '1;
                default:
                    if (is_hue)
                        data = 9'($urandom_range(0, 360));
                    else
                        data = {2'($urandom_range(0, 3)), 7'($urandom_range(0, 100))};
            endcase
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                CFG_BLACK_HUE: window_cfg.black_hue = data;
                CFG_BLACK_SAT: window_cfg.black_sat = data[6:0];
                CFG_BLACK_VAL: window_cfg.black_val = data[6:0];
                CFG_GREEN_HUE: window_cfg.green_hue = data;
                CFG_RED_HUE:   window_cfg.red_hue = data;
                CFG_BLUE_HUE:  window_cfg.blue_hue = data;
                CFG_BLUE_SAT:  window_cfg.blue_sat = data[6:0];
                default:       window_cfg.blue_val = data[6:0];
            endcase
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always
    begin
        repeat ($urandom_range(50, 300)) @(posedge clk);
        src_idles = $urandom_range(0, 3) != 0;
        sink_idles = $urandom_range(0, 3) != 0;
    end

    always @(negedge clk)
    begin
        if (stall_left == 0 && !calm && sink_idles && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_hsv.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result with no request pending: class %0d hue %0d",
                             $time, color_class, hue_fx);
            end
            else
            begin
                oldest_hsv = pending_hsv.pop_front();
                if (color_class !== oldest_hsv.color_class || hue_fx !== oldest_hsv.hue_fx ||
                    sat_fx !== oldest_hsv.sat_fx || value_level !== oldest_hsv.value_level)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: expected class %0d hue %0d sat %0d val %0d, got %0d %0d %0d %0d",
                                 $time, oldest_hsv.color_class, $signed(oldest_hsv.hue_fx),
                                 oldest_hsv.sat_fx, oldest_hsv.value_level,
                                 color_class, hue_fx, sat_fx, value_level);
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(0, 0, 0, 1, CLASS_RED, -64, 0, 0);
        add_row(1023, 1023, 1023, 1, CLASS_RED, -64, 0, 100);
        add_row(1023, 0, 0, 1, CLASS_RED, 0, 6400, 100);
        add_row(0, 1023, 0, 1, CLASS_GREEN, 7680, 6400, 100);
        add_row(0, 0, 1023, 1, CLASS_BLUE, 15360, 6400, 100);
        add_row(1023, 1023, 0, 1, CLASS_YELLOW, 3840, 6400, 100);
        add_row(0, 1023, 1023, 1, CLASS_GREEN, 11520, 6400, 100);
        add_row(1023, 0, 1023, 1, CLASS_RED, -64, 6400, 100);
        add_row(42, 42, 60, 1, CLASS_BLACK, 15360, 1920, 60);
        add_row(1, 0, 0, 0, CLASS_INVALID, 0, 0, 0);
        add_row(0, 1, 0, 0, CLASS_INVALID, 0, 0, 0);
        add_row(0, 0, 1, 0, CLASS_INVALID, 0, 0, 0);
        add_row(99, 99, 99, 0, CLASS_INVALID, 0, 0, 0);
        add_row(101, 50, 0, 0, CLASS_INVALID, 0, 0, 0);
        add_row(100, 0, 50, 0, CLASS_INVALID, 0, 0, 0);
        add_row(100, 0, 33, 0, CLASS_INVALID, 0, 0, 0);
        add_row(512, 256, 768, 0, CLASS_INVALID, 0, 0, 0);
        add_row(341, 682, 1000, 0, CLASS_INVALID, 0, 0, 0);
        add_row(0, 60, 100, 0, CLASS_INVALID, 0, 0, 0);
        add_row(85, 40, 95, 0, CLASS_INVALID, 0, 0, 0);
        add_row(70, 60, 10, 0, CLASS_INVALID, 0, 0, 0);
        add_row(1022, 1021, 1023, 0, CLASS_INVALID, 0, 0, 0);

        foreach (sample_rows[i])
            send_pixel(sample_rows[i].r, sample_rows[i].g, sample_rows[i].b,
                       sample_rows[i].known, sample_rows[i].want);
        send_random(75);
        settle();
        send_random(75);

        settle();
        load_windows(1);
        send_random(120);

        settle();
        load_windows(2);
        send_random(120);

        repeat (3)
        begin
            settle();
            load_windows(3);
            send_random(150);
        end

        settle();
        load_windows(0);
        calm = 1'b1;
        send_random(150);

        @(negedge clk);
        pix_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (bad_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== rgb_hsv_color_classifier.f =====
hdl/rhcc_pkg.sv
hdl/rhcc_prep.sv
hdl/rhcc_div.sv
hdl/rhcc_classify.sv
hdl/rgb_hsv_color_classifier.sv
hdl/rhcc_checker.sv
tb/rgb_hsv_color_classifier_tb.sv
